### sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cal_pkg.sv
// Types and constants of the configuration argument lexer.
package cal_pkg;

  localparam int LINE_BITS  = 32;
  localparam int OUT_LINE_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);
  localparam int TDATA_W    = ((8 + 3 + OUT_LINE_W + 7) / 8) * 8;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;

  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_AEND = 2'd1,
    K_SEND = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE      = 3'd0,
    E_EOL_QUOTE = 3'd1,
    E_CTL_QUOTE = 3'd2,
    E_EOL_ESC   = 3'd3,
    E_BAD_ESC   = 3'd4
  } err_t;

  typedef enum logic [7:0] {
    M_BETWEEN = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_ARG     = 8'b0000_0100,
    M_DQ      = 8'b0000_1000,
    M_SQ      = 8'b0001_0000,
    M_ESC     = 8'b0010_0000,
    M_DONE    = 8'b0100_0000,
    M_ERROR   = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              arg_char;
    err_t                    error_code;
    logic [OUT_LINE_W-1:0]   line_number;
    logic                    last;
  } res_t;

endpackage

### sv/config_argument_lexer.sv
// Configuration argument lexer: splits a byte stream into arguments.
// The lexer takes one byte (or, with s_tlast high, an end-of-stream mark) per cycle while
// s_tready is high and registers its new mode on every accepted input; results go into a
// 4-entry output FIFO, and s_tready is high while at least two entries are free. An input
// gives zero, one or two results (two only when the stream ends inside an argument);
// m_tvalid/m_tready drain one result per cycle, so the sustained rate is one input per
// cycle as long as results are taken at least as fast as they are made. Errors are sticky
// until rst; line numbers start at 1 and saturate.
`include "assert_macros.svh"

module config_argument_lexer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] in_byte
  input  logic                      s_tlast,   // is_end
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [cal_pkg::TDATA_W-1:0] m_tdata, // [7:0] arg_char, [10:8] error_code,
                                               // [42:11] line_number, rest zero
  output logic [1:0]                m_tuser,   // kind
  output logic                      m_tlast    // last
);
  import cal_pkg::*;

  mode_t                mode, mode_next;
  err_t                 err_code, err_code_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  res_t                 fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]  count;

  logic                 accept, pop;
  logic [1:0]           push_n;
  logic [63:0]          line_ext;
  logic [OUT_LINE_W-1:0] line_now;
  logic [7:0]           c;
  logic                 is_end, is_sep, count_lf;
  kind_t                k0, k1;
  logic [7:0]           ch0;
  err_t                 code0;
  logic [1:0]           n_res;
  res_t                 r0, r1;
  res_t                 head;
  logic                 err_out;

  assign c      = s_tdata;
  assign is_end = s_tlast;
  assign is_sep = (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);

  assign line_ext = 64'(line_count);
  assign line_now = (line_ext > 64'(OUT_LINE_W'('1))) ? '1 : line_ext[OUT_LINE_W-1:0];

  assign s_tready = (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign accept   = s_tvalid && s_tready;
  assign head     = fifo[rd_ptr];
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = TDATA_W'({head.line_number, head.error_code, head.arg_char});
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;
  assign err_out  = m_tvalid && (head.kind == K_ERR);

  // Mode update and results for the byte at the input.
  always_comb begin
    mode_next     = mode;
    err_code_next = err_code;
    count_lf      = 1'b0;
    n_res         = 2'd0;
    k0            = K_BYTE;
    k1            = K_SEND;
    ch0           = 8'h00;
    code0         = E_NONE;
    unique case (mode)
      M_BETWEEN, M_ARG: begin
        if (is_end) begin
          mode_next = M_DONE;
          if (mode == M_ARG) begin
            k0    = K_AEND;
            n_res = 2'd2;
          end else begin
            k0    = K_SEND;
            n_res = 2'd1;
          end
        end else if (c == CH_HASH || is_sep) begin
          if (mode == M_ARG) begin
            k0    = K_AEND;
            n_res = 2'd1;
          end
          count_lf  = (c == CH_LF);
          mode_next = (c == CH_HASH) ? M_COMMENT : M_BETWEEN;
        end else if (c == CH_DQ) begin
          mode_next = M_DQ;
        end else if (c == CH_SQ) begin
          mode_next = M_SQ;
        end else if (c == CH_BSL) begin
          mode_next = M_ESC;
        end else begin
          mode_next = M_ARG;
          ch0       = c;
          n_res     = 2'd1;
        end
      end
      M_COMMENT: begin
        if (is_end) begin
          mode_next = M_DONE;
          k0        = K_SEND;
          n_res     = 2'd1;
        end else if (c == CH_LF) begin
          count_lf  = 1'b1;
          mode_next = M_BETWEEN;
        end
      end
      M_DQ, M_SQ: begin
        if (is_end || c == CH_LF || c == CH_TAB || c == CH_CR) begin
          mode_next     = M_ERROR;
          code0         = (is_end || c == CH_LF) ? E_EOL_QUOTE : E_CTL_QUOTE;
          err_code_next = code0;
          k0            = K_ERR;
          n_res         = 2'd1;
        end else if (c == ((mode == M_DQ) ? CH_DQ : CH_SQ)) begin
          mode_next = M_ARG;
        end else begin
          ch0   = c;
          n_res = 2'd1;
        end
      end
      M_ESC: begin
        n_res     = 2'd1;
        mode_next = M_ARG;
        if (is_end || c == CH_LF) begin
          mode_next     = M_ERROR;
          code0         = E_EOL_ESC;
          err_code_next = code0;
          k0            = K_ERR;
        end else if (c == CH_T) begin
          ch0 = CH_TAB;
        end else if (c == CH_N) begin
          ch0 = CH_LF;
        end else if (c == CH_R) begin
          ch0 = CH_CR;
        end else if (c == CH_SPACE || c == CH_DQ || c == CH_HASH || c == CH_SQ ||
                     c == CH_BSL) begin
          ch0 = c;
        end else begin
          mode_next     = M_ERROR;
          code0         = E_BAD_ESC;
          err_code_next = code0;
          k0            = K_ERR;
        end
      end
      M_DONE: begin
        k0    = K_SEND;
        n_res = 2'd1;
      end
      default: begin
        k0    = K_ERR;
        code0 = err_code;
        n_res = 2'd1;
      end
    endcase

    line_count_next = line_count;
    if (count_lf && line_count != '1) begin
      line_count_next = line_count + LINE_BITS'(1);
    end

    r0.kind        = k0;
    r0.arg_char    = ch0;
    r0.error_code  = code0;
    r0.line_number = line_now;
    r0.last        = (n_res == 2'd1);
    r1.kind        = k1;
    r1.arg_char    = 8'h00;
    r1.error_code  = E_NONE;
    r1.line_number = line_now;
    r1.last        = 1'b1;
  end

  assign push_n = accept ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_BETWEEN;
      err_code   <= E_NONE;
      line_count <= LINE_BITS'(1);
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        err_code   <= err_code_next;
        line_count <= line_count_next;
      end
      wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(push_n) - CNT_BITS'(pop);
    end
  end

  // Result storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= r0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + PTR_BITS'(1)] <= r1;
    end
  end

  `ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0 && mode == M_BETWEEN), "bad reset state")
  `ASSERT_CLK(a_count_bound, count <= CNT_BITS'(FIFO_DEPTH), "result FIFO overflow")
  `ASSERT_CLK(a_err_code_set, (mode == M_ERROR) |-> (err_code != E_NONE), "error without code")
  `ASSERT_CLK(a_err_out_code, err_out |-> (m_tdata[10:8] != 3'd0), "error result without code")
  `ASSERT_CLK(a_done_sticky, (accept && mode == M_DONE) |=> (mode == M_DONE), "left stream-end mode")
  `ASSERT_CLK(a_err_sticky, (mode == M_ERROR) |=> (mode == M_ERROR && $stable(err_code)), "error lost")

endmodule
